FILE: design/hpt_pkg.sv
// Package for the homogeneous point transform: shared types and constants.
// Used by hpt_div_cell and homogeneous_point_transform; no dependencies.
package hpt_pkg;

    // Register indexes of the matrix bank.
    typedef enum logic [2:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5,
        REG_ROW3_COLS01 = 3'd6,
        REG_ROW3_COLS23 = 3'd7
    } reg_idx_t;

    // Sideband that travels along the divider chain with each item.
    typedef struct packed {
        logic        valid;
        logic        direction;
        logic        fault;
        logic [2:0]  neg;
    } div_ctl_t;

endpackage

FILE: design/hpt_mac_cell.sv
// One multiply-accumulate cell of the row dot-product chain.
// No dependencies; adds one product to the running sum handed on by its neighbour.
module hpt_mac_cell (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  coef,
    input  logic signed [31:0]  vin,
    input  logic signed [65:0]  acc_in,
    output logic signed [65:0]  acc_out
);

    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;

    // The product is registered before it joins the running sum, so the sum from
    // the previous cell arrives in the cycle after the vector component.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= coef * vin;
            acc_reg  <= acc_in + 66'(prod_reg);
        end
    end

    assign acc_out = acc_reg;

endmodule

FILE: design/hpt_div_cell.sv
// One restoring-division cell: produces one quotient bit for each of three lanes.
// Depends on hpt_pkg for the sideband struct.
module hpt_div_cell #(
    parameter int unsigned NW = 80
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  hpt_pkg::div_ctl_t    ctl_in,
    input  logic [NW-1:0]        num_in [3],
    input  logic [NW-1:0]        rem_in [3],
    input  logic [31:0]          den_in,
    input  logic [2:0][31:0]     pass_in,
    output hpt_pkg::div_ctl_t    ctl_out,
    output logic [NW-1:0]        num_out [3],
    output logic [NW-1:0]        rem_out [3],
    output logic [31:0]          den_out,
    output logic [2:0][31:0]     pass_out
);

    hpt_pkg::div_ctl_t ctl_reg;
    logic [NW-1:0]     num_reg [3];
    logic [NW-1:0]     rem_reg [3];
    logic [NW-1:0]     rem_next [3];
    logic [NW-1:0]     num_next [3];
    logic [31:0]       den_reg;
    logic [2:0][31:0]  pass_reg;

    // Shift in the next numerator bit, subtract the divisor if it fits.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [NW:0] trial;
            trial = {rem_in[i], num_in[i][NW-1]} - {{(NW-31){1'b0}}, den_in};
            if (!trial[NW])
            begin
                rem_next[i] = trial[NW-1:0];
                num_next[i] = {num_in[i][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = {rem_in[i][NW-2:0], num_in[i][NW-1]};
                num_next[i] = {num_in[i][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            pass_reg <= pass_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign pass_out = pass_reg;

endmodule

FILE: design/homogeneous_point_transform.sv
// Homogeneous point transform: each input transfer carries a vector (x, y, z, w) that is
// multiplied by the 4x4 matrix held in eight configuration registers and, for a point,
// divided by the product's w. One transfer can be taken every cycle while the pipeline
// advances. Each passes through the input skew register, the multiply-accumulate chain,
// the rescale and saturation register, 32 + FRAC_BITS (48 by default) restoring-division
// cells and the output register. The whole pipeline advances whenever the output
// register is free or being taken, so a stalled output stalls the input. Write the matrix
// only while no item is in flight.
// Depends on hpt_pkg, hpt_mac_cell and hpt_div_cell.
module homogeneous_point_transform #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    // Configuration port.
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    // tdata: in_x[31:0], in_y[63:32], in_z[95:64], in_w[127:96]
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,
    // tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_w[112:96],
    //        divide_fault[113], zeros above
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [119:0]  m_tdata
);

    localparam int unsigned NW    = 32 + FRAC_BITS;
    localparam int unsigned QB    = NW;
    localparam int unsigned MACL  = 6;
    localparam logic [63:0] ONE   = 64'(64'd1 << FRAC_BITS);

    logic [63:0] regs_reg [8];
    logic        adv;
    logic        out_valid_reg;
    logic [119:0] out_data_reg;

    // Register bank: write on the access phase of a transfer; resets to the identity.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[hpt_pkg::REG_ROW0_COLS01] <= {32'd0, ONE[31:0]};
            regs_reg[hpt_pkg::REG_ROW0_COLS23] <= '0;
            regs_reg[hpt_pkg::REG_ROW1_COLS01] <= {ONE[31:0], 32'd0};
            regs_reg[hpt_pkg::REG_ROW1_COLS23] <= '0;
            regs_reg[hpt_pkg::REG_ROW2_COLS01] <= '0;
            regs_reg[hpt_pkg::REG_ROW2_COLS23] <= {32'd0, ONE[31:0]};
            regs_reg[hpt_pkg::REG_ROW3_COLS01] <= '0;
            regs_reg[hpt_pkg::REG_ROW3_COLS23] <= {ONE[31:0], 32'd0};
        end
        else if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0)
            regs_reg[paddr[5:3]] <= pwdata;
    end
    assign prdata = regs_reg[paddr[5:3]];

    // The pipeline moves when the output register can take a new value.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Input skew line so that each column reaches its cell at the right cycle.
    logic signed [31:0] vin_reg [4][4];
    logic [MACL-1:0]    mvalid_reg;
    logic               mdir_reg [MACL];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                vin_reg[c][0] <= s_tdata[32*c +: 32];
                for (int k = 1; k < 4; k++)
                    vin_reg[c][k] <= vin_reg[c][k-1];
            end
            mdir_reg[0] <= (s_tdata[127:96] == 32'd0);
            for (int k = 1; k < MACL; k++)
                mdir_reg[k] <= mdir_reg[k-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= '0;
        else if (adv)
            mvalid_reg <= {mvalid_reg[MACL-2:0], s_tvalid};
    end

    // MAC cell chain per row; every cell holds while the pipeline is stalled.
    logic signed [65:0] acc [4][5];
    logic signed [65:0] acc_h [4][5];
    genvar r, c;
    generate
        for (r = 0; r < 4; r++)
        begin : g_row
            assign acc_h[r][0] = '0;
            for (c = 0; c < 4; c++)
            begin : g_col
                logic signed [31:0] coef;
                assign coef = regs_reg[2*r + c/2][32*(c%2) +: 32];
                hpt_mac_cell u_mac (
                    .clk     (clk),
                    .en      (adv),
                    .coef    (coef),
                    .vin     (vin_reg[c][c]),
                    .acc_in  (acc_h[r][c]),
                    .acc_out (acc[r][c+1])
                );
                assign acc_h[r][c+1] = acc[r][c+1];
            end
        end
    endgenerate

    // Rescale and saturate each row sum.
    function automatic logic signed [31:0] sat_row(input logic signed [65:0] s);
        logic signed [65:0] t;
        t = s >>> FRAC_BITS;
        if (t > 66'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (t < -66'sh80000000)
            return 32'sh80000000;
        return t[31:0];
    endfunction

    logic signed [31:0] p_reg [4];
    logic               p_valid_reg;
    logic               p_dir_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                p_reg[i] <= sat_row(acc[i][4]);
            p_dir_reg <= mdir_reg[MACL-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (adv)
            p_valid_reg <= mvalid_reg[MACL-1];
    end

    // Divider chain entry: magnitudes and signs.
    hpt_pkg::div_ctl_t ctl [QB+1];
    logic [NW-1:0]     num [QB+1][3];
    logic [NW-1:0]     rem [QB+1][3];
    logic [31:0]       den [QB+1];
    logic [2:0][31:0]  pass [QB+1];
    always_comb
    begin
        logic [32:0] dmag;
        dmag = p_reg[3][31] ? 33'(-{p_reg[3][31], p_reg[3]}) : {1'b0, p_reg[3]};
        ctl[0].valid     = p_valid_reg;
        ctl[0].direction = p_dir_reg;
        ctl[0].fault     = !p_dir_reg && p_reg[3] == 32'd0;
        den[0]           = dmag[31:0];
        for (int i = 0; i < 3; i++)
        begin
            logic [32:0] nmag;
            nmag = p_reg[i][31] ? 33'(-{p_reg[i][31], p_reg[i]}) : {1'b0, p_reg[i]};
            ctl[0].neg[i] = p_reg[i][31] != p_reg[3][31];
            num[0][i]     = NW'({nmag[31:0], {FRAC_BITS{1'b0}}});
            rem[0][i]     = '0;
            pass[0][i]    = p_reg[i];
        end
    end

    generate
        for (c = 0; c < QB; c++)
        begin : g_div
            hpt_div_cell #(.NW(NW)) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (adv),
                .ctl_in   (ctl[c]),
                .num_in   (num[c]),
                .rem_in   (rem[c]),
                .den_in   (den[c]),
                .pass_in  (pass[c]),
                .ctl_out  (ctl[c+1]),
                .num_out  (num[c+1]),
                .rem_out  (rem[c+1]),
                .den_out  (den[c+1]),
                .pass_out (pass[c+1])
            );
        end
    endgenerate

    // Final sign, saturation and result selection.
    logic [119:0] out_data_next;
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            logic [QB-1:0] q;
            logic [31:0]   v;
            q = num[QB][i][QB-1:0];
            if (ctl[QB].neg[i])
                v = (q >= QB'(33'h80000000)) ? 32'h80000000 : 32'(-q);
            else
                v = (q > QB'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
            if (ctl[QB].direction)
                out_data_next[32*i +: 32] = pass[QB][i];
            else if (!ctl[QB].fault)
                out_data_next[32*i +: 32] = v;
        end
        if (!ctl[QB].direction && !ctl[QB].fault)
            out_data_next[112:96] = ONE[16:0];
        out_data_next[113] = ctl[QB].fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= ctl[QB].valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A faulted result must carry zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[113] |-> m_tdata[112:0] == '0)
        else $error("fault result not zero");
    // A stalled output holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    // Input is taken exactly when the pipeline advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready mismatch");

endmodule
